[design/cir_pkg.sv]
// Shared types, constants and helpers for the contact impulse resolver.
package cir_pkg;

  localparam logic [15:0] E_ONE   = 16'd32768;  // restitution 1.0 in Q1.15
  localparam logic [15:0] PCT_MAX = 16'd31130;  // correction percent 0.95 in Q1.15

  // Contact fields that ride along with the reciprocal and weight divider.
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [30:0]        depth;
    logic [15:0]        rest;
    logic [15:0]        fric;
    logic [15:0]        pct;
  } cir_ctx_t;

  // Divider result: body A weight in Q.16 plus mass flags.
  typedef struct packed {
    cir_ctx_t    ctx;
    logic [16:0] wa;
    logic        inv_a_nz;
    logic        inv_b_nz;
    logic        stat;
  } cir_wgt_t;

  // Impulse result: velocities after restitution and friction.
  typedef struct packed {
    logic signed [42:0] ax;
    logic signed [42:0] ay;
    logic signed [42:0] bx;
    logic signed [42:0] by;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [30:0]        depth;
    logic [15:0]        pct;
    logic [16:0]        wa;
    logic [16:0]        wb;
    logic               inv_a_nz;
    logic               inv_b_nz;
    logic               stat;
    logic signed [31:0] vn;
  } cir_vel_t;

  // Final unsaturated result.
  typedef struct packed {
    logic signed [47:0] ax;
    logic signed [47:0] ay;
    logic signed [47:0] bx;
    logic signed [47:0] by;
    logic signed [36:0] sax;
    logic signed [36:0] say;
    logic signed [36:0] sbx;
    logic signed [36:0] sby;
    logic signed [31:0] vn;
    logic               stat;
  } cir_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[design/cir_div.sv]
// Pipelined restoring dividers: both mass reciprocals, then body A weight.
module cir_div import cir_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] mass_a_i,
  input  logic [31:0] mass_b_i,
  input  cir_ctx_t    ctx_i,
  output logic        valid_o,
  output cir_wgt_t    wgt_o
);

  localparam int TWO_F = 2 * FRAC_BITS;
  localparam logic [32:0] REM0 = (TWO_F >= 32) ? (33'd1 << (TWO_F - 32)) : 33'd0;
  localparam int NS = 51;  // load, 32 reciprocal steps, sum, 17 weight steps

  typedef struct packed {
    cir_ctx_t    ctx;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] ra;
    logic [32:0] rb;
    logic [31:0] qa;
    logic [31:0] qb;
    logic        sa;
    logic        sb;
    logic [31:0] ia;
    logic [31:0] ib;
    logic [32:0] isum;
    logic [33:0] rw;
    logic [16:0] qw;
  } div_t;

  div_t            st_q [NS];
  div_t            st_d [NS];
  logic [NS-1:0]   vld_q;

  always_comb begin
    st_d[0]     = st_q[0];
    st_d[0].ctx = ctx_i;
    st_d[0].ma  = mass_a_i;
    st_d[0].mb  = mass_b_i;
    st_d[0].ra  = REM0;
    st_d[0].rb  = REM0;
    st_d[0].qa  = '0;
    st_d[0].qb  = '0;
    st_d[0].sa  = (mass_a_i != '0) && ({1'b0, mass_a_i} <= REM0);
    st_d[0].sb  = (mass_b_i != '0) && ({1'b0, mass_b_i} <= REM0);
  end

  // One quotient bit per stage for each reciprocal.
  for (genvar k = 0; k < 32; k++) begin : g_rcp
    localparam int BI = 31 - k;
    localparam logic DB = (BI == TWO_F);
    logic [32:0] rsa, rsb;
    always_comb begin
      st_d[k+1] = st_q[k];
      rsa = {st_q[k].ra[31:0], DB};
      rsb = {st_q[k].rb[31:0], DB};
      if (rsa >= {1'b0, st_q[k].ma}) begin
        st_d[k+1].ra = rsa - {1'b0, st_q[k].ma};
        st_d[k+1].qa = {st_q[k].qa[30:0], 1'b1};
      end else begin
        st_d[k+1].ra = rsa;
        st_d[k+1].qa = {st_q[k].qa[30:0], 1'b0};
      end
      if (rsb >= {1'b0, st_q[k].mb}) begin
        st_d[k+1].rb = rsb - {1'b0, st_q[k].mb};
        st_d[k+1].qb = {st_q[k].qb[30:0], 1'b1};
      end else begin
        st_d[k+1].rb = rsb;
        st_d[k+1].qb = {st_q[k].qb[30:0], 1'b0};
      end
    end
  end

  // Finish reciprocals with saturation, form the sum and seed the weight divide.
  logic [31:0] fin_a, fin_b;
  always_comb begin
    st_d[33] = st_q[32];
    fin_a = (st_q[32].ma == '0) ? 32'd0 : (st_q[32].sa ? 32'hFFFFFFFF : st_q[32].qa);
    fin_b = (st_q[32].mb == '0) ? 32'd0 : (st_q[32].sb ? 32'hFFFFFFFF : st_q[32].qb);
    st_d[33].ia   = fin_a;
    st_d[33].ib   = fin_b;
    st_d[33].isum = 33'(fin_a) + 33'(fin_b);
    st_d[33].rw   = 34'(fin_a >> 1);
    st_d[33].qw   = '0;
  end

  for (genvar j = 0; j < 17; j++) begin : g_wgt
    localparam int BI = 16 - j;
    logic [33:0] rs;
    always_comb begin
      st_d[34+j] = st_q[33+j];
      rs = {st_q[33+j].rw[32:0], (BI == 16) ? st_q[33+j].ia[0] : 1'b0};
      if (rs >= {1'b0, st_q[33+j].isum}) begin
        st_d[34+j].rw = rs - {1'b0, st_q[33+j].isum};
        st_d[34+j].qw = {st_q[33+j].qw[15:0], 1'b1};
      end else begin
        st_d[34+j].rw = rs;
        st_d[34+j].qw = {st_q[33+j].qw[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o        = vld_q[NS-1];
  assign wgt_o.ctx      = st_q[NS-1].ctx;
  assign wgt_o.wa       = st_q[NS-1].qw;
  assign wgt_o.inv_a_nz = (st_q[NS-1].ia != '0);
  assign wgt_o.inv_b_nz = (st_q[NS-1].ib != '0);
  assign wgt_o.stat     = (st_q[NS-1].isum == '0);

endmodule

[design/cir_impulse.sv]
// Restitution and friction impulse pipeline.
module cir_impulse import cir_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] min_tan_len_sq_i,
  input  logic        valid_i,
  input  cir_wgt_t    wgt_i,
  output logic        valid_o,
  output cir_vel_t    vel_o
);

  localparam int NS = 15;

  typedef struct packed {
    cir_wgt_t           w;
    logic [16:0]        wb;
    logic [16:0]        k;
    logic signed [32:0] rx;
    logic signed [32:0] ry;
    logic signed [48:0] prx;
    logic signed [48:0] pry;
    logic signed [31:0] vn;
    logic [32:0]        dv;
    logic [33:0]        da;
    logic [33:0]        db;
    logic [36:0]        lim;
    logic signed [49:0] pnxa;
    logic signed [49:0] pnya;
    logic signed [49:0] pnxb;
    logic signed [49:0] pnyb;
    logic signed [36:0] ax1;
    logic signed [36:0] ay1;
    logic signed [36:0] bx1;
    logic signed [36:0] by1;
    logic signed [37:0] qx;
    logic signed [37:0] qy;
    logic signed [53:0] t1;
    logic signed [53:0] t2;
    logic signed [40:0] s;
    logic [40:0]        mag;
    logic               hi;
    logic [63:0]        sq;
    logic [36:0]        m;
    logic signed [16:0] tx;
    logic signed [16:0] ty;
    logic [37:0]        fa;
    logic [37:0]        fb;
    logic signed [55:0] ptxa;
    logic signed [55:0] ptya;
    logic signed [55:0] ptxb;
    logic signed [55:0] ptyb;
    logic signed [42:0] ax2;
    logic signed [42:0] ay2;
    logic signed [42:0] bx2;
    logic signed [42:0] by2;
  } imp_t;

  imp_t          st_q [NS];
  imp_t          st_d [NS];
  logic [NS-1:0] vld_q;

  logic [32:0] nvn;
  logic        app;
  logic        go;

  always_comb begin
    // relative velocity, clamped restitution
    st_d[0]    = st_q[0];
    st_d[0].w  = wgt_i;
    st_d[0].wb = 17'h10000 - wgt_i.wa;
    st_d[0].k  = 17'(E_ONE) + 17'((wgt_i.ctx.rest > E_ONE) ? E_ONE : wgt_i.ctx.rest);
    st_d[0].rx = 33'(wgt_i.ctx.vbx) - 33'(wgt_i.ctx.vax);
    st_d[0].ry = 33'(wgt_i.ctx.vby) - 33'(wgt_i.ctx.vay);

    st_d[1]     = st_q[0];
    st_d[1].prx = 49'(st_q[0].rx) * 49'(st_q[0].w.ctx.nx);
    st_d[1].pry = 49'(st_q[0].ry) * 49'(st_q[0].w.ctx.ny);

    st_d[2]    = st_q[1];
    st_d[2].vn = sat32(64'((50'(st_q[1].prx) + 50'(st_q[1].pry)) >>> 14));

    // approach speed scaled by (1 + e); zero when separating or both static
    st_d[3] = st_q[2];
    app = (st_q[2].vn < 0) && !st_q[2].w.stat;
    nvn = 33'(0) - 33'(st_q[2].vn);
    st_d[3].dv = app ? 33'((49'(st_q[2].k) * 49'(nvn[31:0])) >> 15) : 33'd0;

    st_d[4]     = st_q[3];
    st_d[4].da  = 34'((50'(st_q[3].dv) * 50'(st_q[3].w.wa)) >> 16);
    st_d[4].db  = 34'((50'(st_q[3].dv) * 50'(st_q[3].wb)) >> 16);
    st_d[4].lim = 37'((49'(st_q[3].dv) * 49'(st_q[3].w.ctx.fric)) >> 12);

    st_d[5]      = st_q[4];
    st_d[5].pnxa = 50'(st_q[4].w.ctx.nx) * 50'($signed({1'b0, st_q[4].da}));
    st_d[5].pnya = 50'(st_q[4].w.ctx.ny) * 50'($signed({1'b0, st_q[4].da}));
    st_d[5].pnxb = 50'(st_q[4].w.ctx.nx) * 50'($signed({1'b0, st_q[4].db}));
    st_d[5].pnyb = 50'(st_q[4].w.ctx.ny) * 50'($signed({1'b0, st_q[4].db}));

    st_d[6]     = st_q[5];
    st_d[6].ax1 = 37'(st_q[5].w.ctx.vax) - 37'(st_q[5].pnxa >>> 14);
    st_d[6].ay1 = 37'(st_q[5].w.ctx.vay) - 37'(st_q[5].pnya >>> 14);
    st_d[6].bx1 = 37'(st_q[5].w.ctx.vbx) + 37'(st_q[5].pnxb >>> 14);
    st_d[6].by1 = 37'(st_q[5].w.ctx.vby) + 37'(st_q[5].pnyb >>> 14);

    st_d[7]    = st_q[6];
    st_d[7].qx = 38'(st_q[6].bx1) - 38'(st_q[6].ax1);
    st_d[7].qy = 38'(st_q[6].by1) - 38'(st_q[6].ay1);

    st_d[8]    = st_q[7];
    st_d[8].t1 = 54'(st_q[7].qy) * 54'(st_q[7].w.ctx.nx);
    st_d[8].t2 = 54'(st_q[7].qx) * 54'(st_q[7].w.ctx.ny);

    // signed tangential speed
    st_d[9]   = st_q[8];
    st_d[9].s = 41'((55'(st_q[8].t1) - 55'(st_q[8].t2)) >>> 14);

    st_d[10]     = st_q[9];
    st_d[10].mag = st_q[9].s[40] ? 41'(-st_q[9].s) : 41'(st_q[9].s);
    st_d[10].hi  = 1'b0;
    st_d[10].sq  = '0;
    st_d[10].hi  = |st_d[10].mag[40:32];
    st_d[10].sq  = 64'(st_d[10].mag[31:0]) * 64'(st_d[10].mag[31:0]);

    // Coulomb clamp; drop friction below the tangent threshold
    st_d[11] = st_q[10];
    go = st_q[10].hi || ((st_q[10].sq >> FRAC_BITS) > 64'(min_tan_len_sq_i));
    if (!go) begin
      st_d[11].m = '0;
    end else if (41'(st_q[10].lim) < st_q[10].mag) begin
      st_d[11].m = st_q[10].lim;
    end else begin
      st_d[11].m = 37'(st_q[10].mag);
    end
    st_d[11].tx = st_q[10].s[40] ? 17'(st_q[10].w.ctx.ny) : -17'(st_q[10].w.ctx.ny);
    st_d[11].ty = st_q[10].s[40] ? -17'(st_q[10].w.ctx.nx) : 17'(st_q[10].w.ctx.nx);

    st_d[12]    = st_q[11];
    st_d[12].fa = 38'((54'(st_q[11].m) * 54'(st_q[11].w.wa)) >> 16);
    st_d[12].fb = 38'((54'(st_q[11].m) * 54'(st_q[11].wb)) >> 16);

    st_d[13]      = st_q[12];
    st_d[13].ptxa = 56'(st_q[12].tx) * 56'($signed({1'b0, st_q[12].fa}));
    st_d[13].ptya = 56'(st_q[12].ty) * 56'($signed({1'b0, st_q[12].fa}));
    st_d[13].ptxb = 56'(st_q[12].tx) * 56'($signed({1'b0, st_q[12].fb}));
    st_d[13].ptyb = 56'(st_q[12].ty) * 56'($signed({1'b0, st_q[12].fb}));

    st_d[14]     = st_q[13];
    st_d[14].ax2 = 43'(st_q[13].ax1) + 43'(st_q[13].ptxa >>> 14);
    st_d[14].ay2 = 43'(st_q[13].ay1) + 43'(st_q[13].ptya >>> 14);
    st_d[14].bx2 = 43'(st_q[13].bx1) - 43'(st_q[13].ptxb >>> 14);
    st_d[14].by2 = 43'(st_q[13].by1) - 43'(st_q[13].ptyb >>> 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o        = vld_q[NS-1];
  assign vel_o.ax       = st_q[NS-1].ax2;
  assign vel_o.ay       = st_q[NS-1].ay2;
  assign vel_o.bx       = st_q[NS-1].bx2;
  assign vel_o.by       = st_q[NS-1].by2;
  assign vel_o.nx       = st_q[NS-1].w.ctx.nx;
  assign vel_o.ny       = st_q[NS-1].w.ctx.ny;
  assign vel_o.depth    = st_q[NS-1].w.ctx.depth;
  assign vel_o.pct      = st_q[NS-1].w.ctx.pct;
  assign vel_o.wa       = st_q[NS-1].w.wa;
  assign vel_o.wb       = st_q[NS-1].wb;
  assign vel_o.inv_a_nz = st_q[NS-1].w.inv_a_nz;
  assign vel_o.inv_b_nz = st_q[NS-1].w.inv_b_nz;
  assign vel_o.stat     = st_q[NS-1].w.stat;
  assign vel_o.vn       = st_q[NS-1].vn;

endmodule

[design/cir_settle.sv]
// Position correction and deep contact velocity damping pipeline.
module cir_settle import cir_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  cir_vel_t vel_i,
  output logic     valid_o,
  output cir_res_t res_o
);

  localparam logic [30:0] SLOP  = 31'((2 ** FRAC_BITS + 5000) / 10000);
  localparam logic [32:0] SLOP2 = 33'(SLOP) * 33'd2;
  localparam logic [32:0] SLOP3 = 33'(SLOP) * 33'd3;
  localparam int NS = 7;

  typedef struct packed {
    cir_vel_t           v;
    logic [30:0]        base;
    logic [14:0]        p;
    logic               deep2;
    logic               deep3;
    logic [45:0]        prod;
    logic [31:0]        corr;
    logic [32:0]        ca;
    logic [32:0]        cb;
    logic signed [58:0] pax;
    logic signed [58:0] pay;
    logic signed [58:0] pbx;
    logic signed [58:0] pby;
    logic signed [49:0] pnxa;
    logic signed [49:0] pnya;
    logic signed [49:0] pnxb;
    logic signed [49:0] pnyb;
    logic signed [45:0] vna;
    logic signed [45:0] vnb;
    logic signed [36:0] sax;
    logic signed [36:0] say;
    logic signed [36:0] sbx;
    logic signed [36:0] sby;
    logic               doa;
    logic               dob;
    logic signed [61:0] qxa;
    logic signed [61:0] qya;
    logic signed [61:0] qxb;
    logic signed [61:0] qyb;
    logic signed [47:0] ax;
    logic signed [47:0] ay;
    logic signed [47:0] bx;
    logic signed [47:0] by;
  } set_t;

  set_t          st_q [NS];
  set_t          st_d [NS];
  logic [NS-1:0] vld_q;

  always_comb begin
    st_d[0]       = st_q[0];
    st_d[0].v     = vel_i;
    st_d[0].base  = (vel_i.depth > SLOP) ? (vel_i.depth - SLOP) : 31'd0;
    st_d[0].p     = (vel_i.pct > PCT_MAX) ? 15'(PCT_MAX) : 15'(vel_i.pct);
    st_d[0].deep2 = (33'(vel_i.depth) > SLOP2);
    st_d[0].deep3 = (33'(vel_i.depth) > SLOP3);

    st_d[1]      = st_q[0];
    st_d[1].prod = 46'(st_q[0].base) * 46'(st_q[0].p);

    // boost deep contacts by 1.5
    st_d[2]      = st_q[1];
    st_d[2].corr = st_q[1].deep2 ? 32'((48'(st_q[1].prod) * 48'd3) >> 16)
                                 : 32'(st_q[1].prod >> 15);

    st_d[3]     = st_q[2];
    st_d[3].ca  = 33'((49'(st_q[2].corr) * 49'(st_q[2].v.wa)) >> 16);
    st_d[3].cb  = 33'((49'(st_q[2].corr) * 49'(st_q[2].v.wb)) >> 16);
    st_d[3].pax = 59'(st_q[2].v.ax) * 59'(st_q[2].v.nx);
    st_d[3].pay = 59'(st_q[2].v.ay) * 59'(st_q[2].v.ny);
    st_d[3].pbx = 59'(st_q[2].v.bx) * 59'(st_q[2].v.nx);
    st_d[3].pby = 59'(st_q[2].v.by) * 59'(st_q[2].v.ny);

    st_d[4]      = st_q[3];
    st_d[4].pnxa = 50'(st_q[3].v.nx) * 50'($signed({1'b0, st_q[3].ca}));
    st_d[4].pnya = 50'(st_q[3].v.ny) * 50'($signed({1'b0, st_q[3].ca}));
    st_d[4].pnxb = 50'(st_q[3].v.nx) * 50'($signed({1'b0, st_q[3].cb}));
    st_d[4].pnyb = 50'(st_q[3].v.ny) * 50'($signed({1'b0, st_q[3].cb}));
    st_d[4].vna  = 46'((60'(st_q[3].pax) + 60'(st_q[3].pay)) >>> 14);
    st_d[4].vnb  = 46'((60'(st_q[3].pbx) + 60'(st_q[3].pby)) >>> 14);

    // A is pushed against the normal, B along it
    st_d[5]     = st_q[4];
    st_d[5].sax = -37'(st_q[4].pnxa >>> 14);
    st_d[5].say = -37'(st_q[4].pnya >>> 14);
    st_d[5].sbx = 37'(st_q[4].pnxb >>> 14);
    st_d[5].sby = 37'(st_q[4].pnyb >>> 14);
    st_d[5].doa = st_q[4].deep3 && (st_q[4].vna < 0) && st_q[4].v.inv_a_nz;
    st_d[5].dob = st_q[4].deep3 && (st_q[4].vnb > 0) && st_q[4].v.inv_b_nz;
    st_d[5].qxa = 62'(st_q[4].v.nx) * 62'(st_q[4].vna);
    st_d[5].qya = 62'(st_q[4].v.ny) * 62'(st_q[4].vna);
    st_d[5].qxb = 62'(st_q[4].v.nx) * 62'(st_q[4].vnb);
    st_d[5].qyb = 62'(st_q[4].v.ny) * 62'(st_q[4].vnb);

    // halve the inward normal component
    st_d[6]    = st_q[5];
    st_d[6].ax = st_q[5].doa ? 48'(st_q[5].v.ax) - 48'(st_q[5].qxa >>> 15)
                             : 48'(st_q[5].v.ax);
    st_d[6].ay = st_q[5].doa ? 48'(st_q[5].v.ay) - 48'(st_q[5].qya >>> 15)
                             : 48'(st_q[5].v.ay);
    st_d[6].bx = st_q[5].dob ? 48'(st_q[5].v.bx) - 48'(st_q[5].qxb >>> 15)
                             : 48'(st_q[5].v.bx);
    st_d[6].by = st_q[5].dob ? 48'(st_q[5].v.by) - 48'(st_q[5].qyb >>> 15)
                             : 48'(st_q[5].v.by);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o    = vld_q[NS-1];
  assign res_o.ax   = st_q[NS-1].ax;
  assign res_o.ay   = st_q[NS-1].ay;
  assign res_o.bx   = st_q[NS-1].bx;
  assign res_o.by   = st_q[NS-1].by;
  assign res_o.sax  = st_q[NS-1].sax;
  assign res_o.say  = st_q[NS-1].say;
  assign res_o.sbx  = st_q[NS-1].sbx;
  assign res_o.sby  = st_q[NS-1].sby;
  assign res_o.vn   = st_q[NS-1].v.vn;
  assign res_o.stat = st_q[NS-1].v.stat;

endmodule

[design/contact_impulse_resolver_top.sv]
// Top level of the 2D contact impulse resolver pipeline.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  request   | start, busy           | mass_*_i, vel_*_i, normal_*_i, depth_i, ...
//  result    | done_o (one cycle)    | new_vel_*_o, shift_*_o, rel_normal_vel_o, ...
//  config    | cfg_we_i              | cfg_wdata_i -> min_tangent_len_sq
//
// A request is taken every cycle; busy is never raised. Each result reaches
// done_o through 51 stages of the bit-per-stage reciprocal and weight
// dividers, 15 impulse stages, 7 correction stages and the output register.
// Reset clears only the valid bits and the threshold register (to 1). The
// receiver cannot stall, so nothing ever holds.
module contact_impulse_resolver_top import cir_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        mass_a_i,
  input  logic [31:0]        mass_b_i,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic [30:0]        depth_i,
  input  logic [15:0]        restitution_i,
  input  logic [15:0]        friction_i,
  input  logic [15:0]        correct_percent_i,
  output logic               done_o,
  output logic signed [31:0] new_vel_a_x_o,
  output logic signed [31:0] new_vel_a_y_o,
  output logic signed [31:0] new_vel_b_x_o,
  output logic signed [31:0] new_vel_b_y_o,
  output logic signed [31:0] shift_a_x_o,
  output logic signed [31:0] shift_a_y_o,
  output logic signed [31:0] shift_b_x_o,
  output logic signed [31:0] shift_b_y_o,
  output logic signed [31:0] rel_normal_vel_o,
  output logic               both_static_o
);

  logic [31:0] min_tan_q;
  cir_ctx_t    ctx;
  logic        div_vld, imp_vld, set_vld;
  cir_wgt_t    wgt;
  cir_vel_t    vel;
  cir_res_t    res;
  logic        done_q;
  logic signed [31:0] nvax_q, nvay_q, nvbx_q, nvby_q;
  logic signed [31:0] sax_q, say_q, sbx_q, sby_q, vn_q;
  logic        stat_q;

  // Fully pipelined: never hold a request off.
  assign busy = 1'b0;

  // Friction threshold; the user must write it only while the pipe is empty, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_tan_q <= 32'd1;
    end else if (cfg_we_i) begin
      min_tan_q <= cfg_wdata_i;
    end
  end

  assign ctx.vax   = vel_a_x_i;
  assign ctx.vay   = vel_a_y_i;
  assign ctx.vbx   = vel_b_x_i;
  assign ctx.vby   = vel_b_y_i;
  assign ctx.nx    = normal_x_i;
  assign ctx.ny    = normal_y_i;
  assign ctx.depth = depth_i;
  assign ctx.rest  = restitution_i;
  assign ctx.fric  = friction_i;
  assign ctx.pct   = correct_percent_i;

  // Reciprocals of both masses and the share of body A.
  cir_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .mass_a_i (mass_a_i),
    .mass_b_i (mass_b_i),
    .ctx_i    (ctx),
    .valid_o  (div_vld),
    .wgt_o    (wgt)
  );

  // Normal restitution impulse, then friction along the tangent.
  cir_impulse #(.FRAC_BITS(FRAC_BITS)) u_imp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .min_tan_len_sq_i (min_tan_q),
    .valid_i          (div_vld),
    .wgt_i            (wgt),
    .valid_o          (imp_vld),
    .vel_o            (vel)
  );

  // Position offsets and deep contact damping.
  cir_settle #(.FRAC_BITS(FRAC_BITS)) u_set (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (imp_vld),
    .vel_i   (vel),
    .valid_o (set_vld),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= set_vld;
    end
  end

  // Saturate velocities and offsets; a contact of two static bodies reports no offsets and zero normal velocity.
  always_ff @(posedge clk_i) begin
    nvax_q <= sat32(64'(res.ax));
    nvay_q <= sat32(64'(res.ay));
    nvbx_q <= sat32(64'(res.bx));
    nvby_q <= sat32(64'(res.by));
    sax_q  <= res.stat ? 32'sd0 : sat32(64'(res.sax));
    say_q  <= res.stat ? 32'sd0 : sat32(64'(res.say));
    sbx_q  <= res.stat ? 32'sd0 : sat32(64'(res.sbx));
    sby_q  <= res.stat ? 32'sd0 : sat32(64'(res.sby));
    vn_q   <= res.stat ? 32'sd0 : res.vn;
    stat_q <= res.stat;
  end

  assign done_o           = done_q;
  assign new_vel_a_x_o    = nvax_q;
  assign new_vel_a_y_o    = nvay_q;
  assign new_vel_b_x_o    = nvbx_q;
  assign new_vel_b_y_o    = nvby_q;
  assign shift_a_x_o      = sax_q;
  assign shift_a_y_o      = say_q;
  assign shift_b_x_o      = sbx_q;
  assign shift_b_y_o      = sby_q;
  assign rel_normal_vel_o = vn_q;
  assign both_static_o    = stat_q;

endmodule
